### hdl/lgep_pkg.sv
package lgep_pkg;

	localparam int GRID_W = 16;
	localparam int GRID_H = 16;
	localparam int PAD_W = GRID_W + 2;
	localparam int PAD_H = GRID_H + 2;
	localparam int NCELLS = GRID_W * GRID_H;
	localparam int NPAD = PAD_W * PAD_H;
	localparam int STACK_DEPTH = 512;
	localparam int PAD_AW = $clog2(NPAD);
	localparam int ID_W = $clog2(NCELLS);
	localparam int SP_W = $clog2(STACK_DEPTH + 1);
	localparam int STK_AW = $clog2(STACK_DEPTH);
	localparam logic [3:0] ALL_ONES = 4'b1111;

	typedef enum logic [1:0] {
		KIND_LOAD = 2'd0,
		KIND_DRIVE = 2'd1,
		KIND_PROP = 2'd2,
		KIND_READ = 2'd3
	} kind_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DRIVE,
		ST_POP,
		ST_POP_WAIT,
		ST_NB0,
		ST_NB1,
		ST_NB2,
		ST_NB3,
		ST_NB_WAIT,
		ST_EVAL,
		ST_PUSH0,
		ST_PUSH1,
		ST_PUSH2,
		ST_PUSH3,
		ST_READ_WAIT,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clear_step;
		logic capture;
		logic load_table;
		logic drive_set;
		logic push_cmd;
		logic pop;
		logic [1:0] nb_rd;
		logic nb_cap;
		logic [2:0] nb_sel;
		logic tbl_rd;
		logic self_rd;
		logic eval_write;
		logic push_nb;
		logic [1:0] push_dir;
		logic read_rd;
		logic read_cap;
		logic clr_count;
		logic result_load;
		logic is_prop;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_done;
		logic in_grid;
		logic stack_empty;
		logic at_limit;
		logic id_valid;
		logic changed;
	} stat_t;

	function automatic logic [PAD_AW-1:0] pad_idx(input logic [8:0] c, input logic [8:0] r);
		logic [PAD_AW+8:0] t;
		t = (PAD_AW + 9)'(r) * (PAD_AW + 9)'(PAD_W) + (PAD_AW + 9)'(c);
		return t[PAD_AW-1:0];
	endfunction

endpackage

### hdl/lgep_ram.sv
module lgep_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

### hdl/lgep_ctrl.sv
module lgep_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        kind,
	output logic              out_valid,
	input  logic              out_stall,
	input  lgep_pkg::stat_t   st,
	output lgep_pkg::cmd_t    cmd
);

	lgep_pkg::state_t state_q, state_d;
	logic out_valid_q, out_valid_d;
	logic [1:0] kind_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lgep_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
			kind_q <= 2'd0;
		end else begin
			state_q <= state_d;
			out_valid_q <= out_valid_d;
			if (cmd.capture) kind_q <= kind;
		end
	end

	assign out_valid = out_valid_q;
	assign in_stall = (state_q != lgep_pkg::ST_IDLE) || out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		out_valid_d = out_valid_q && out_stall;
		cmd = '0;
		cmd.is_prop = (kind_q == lgep_pkg::KIND_PROP);
		unique case (state_q)
			lgep_pkg::ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (st.clear_done) state_d = lgep_pkg::ST_IDLE;
			end
			lgep_pkg::ST_IDLE: begin
				if (in_valid && !out_valid_q) begin
					cmd.capture = 1'b1;
					unique case (lgep_pkg::kind_t'(kind))
						lgep_pkg::KIND_LOAD: state_d = lgep_pkg::ST_DONE;
						lgep_pkg::KIND_DRIVE: state_d = lgep_pkg::ST_DRIVE;
						lgep_pkg::KIND_PROP: state_d = lgep_pkg::ST_POP;
						lgep_pkg::KIND_READ: state_d = lgep_pkg::ST_READ_WAIT;
						default: state_d = lgep_pkg::ST_DONE;
					endcase
				end
			end
			lgep_pkg::ST_DRIVE: begin
				if (st.in_grid) begin
					cmd.push_cmd = 1'b1;
					cmd.drive_set = 1'b1;
				end
				state_d = lgep_pkg::ST_DONE;
			end
			lgep_pkg::ST_READ_WAIT: begin
				cmd.read_rd = 1'b1;
				state_d = lgep_pkg::ST_DONE;
			end
			lgep_pkg::ST_POP: begin
				if (st.stack_empty || st.at_limit) begin
					state_d = lgep_pkg::ST_DONE;
				end else begin
					cmd.pop = 1'b1;
					state_d = lgep_pkg::ST_POP_WAIT;
				end
			end
			lgep_pkg::ST_POP_WAIT: begin
				state_d = lgep_pkg::ST_NB0;
			end
			lgep_pkg::ST_NB0: begin
				if (!st.id_valid) begin
					state_d = lgep_pkg::ST_POP;
				end else begin
					cmd.nb_rd = 2'd0;
					cmd.tbl_rd = 1'b1;
					state_d = lgep_pkg::ST_NB1;
				end
			end
			lgep_pkg::ST_NB1: begin
				cmd.nb_rd = 2'd1;
				cmd.nb_cap = 1'b1;
				cmd.nb_sel = 3'd0;
				state_d = lgep_pkg::ST_NB2;
			end
			lgep_pkg::ST_NB2: begin
				cmd.nb_rd = 2'd2;
				cmd.nb_cap = 1'b1;
				cmd.nb_sel = 3'd1;
				state_d = lgep_pkg::ST_NB3;
			end
			lgep_pkg::ST_NB3: begin
				cmd.nb_rd = 2'd3;
				cmd.nb_cap = 1'b1;
				cmd.nb_sel = 3'd2;
				state_d = lgep_pkg::ST_NB_WAIT;
			end
			lgep_pkg::ST_NB_WAIT: begin
				cmd.self_rd = 1'b1;
				cmd.nb_cap = 1'b1;
				cmd.nb_sel = 3'd3;
				state_d = lgep_pkg::ST_EVAL;
			end
			lgep_pkg::ST_EVAL: begin
				cmd.nb_cap = 1'b1;
				cmd.nb_sel = 3'd4;
				state_d = lgep_pkg::ST_PUSH0;
			end
			lgep_pkg::ST_PUSH0: begin
				if (!st.changed) begin
					state_d = lgep_pkg::ST_POP;
				end else begin
					cmd.eval_write = 1'b1;
					cmd.push_nb = 1'b1;
					cmd.push_dir = 2'd0;
					state_d = lgep_pkg::ST_PUSH1;
				end
			end
			lgep_pkg::ST_PUSH1: begin
				cmd.push_nb = 1'b1;
				cmd.push_dir = 2'd1;
				state_d = lgep_pkg::ST_PUSH2;
			end
			lgep_pkg::ST_PUSH2: begin
				cmd.push_nb = 1'b1;
				cmd.push_dir = 2'd2;
				state_d = lgep_pkg::ST_PUSH3;
			end
			lgep_pkg::ST_PUSH3: begin
				cmd.push_nb = 1'b1;
				cmd.push_dir = 2'd3;
				state_d = lgep_pkg::ST_POP;
			end
			lgep_pkg::ST_DONE: begin
				cmd.result_load = 1'b1;
				cmd.read_cap = 1'b1;
				out_valid_d = 1'b1;
				state_d = lgep_pkg::ST_IDLE;
			end
			default: state_d = lgep_pkg::ST_IDLE;
		endcase
	end

endmodule

### hdl/lgep_dp.sv
module lgep_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  lgep_pkg::cmd_t    cmd,
	output lgep_pkg::stat_t   st,
	input  logic [1:0]        kind,
	input  logic [3:0]        col,
	input  logic [3:0]        row,
	input  logic [1:0]        side,
	input  logic [63:0]       table_word,
	input  logic              level,
	input  logic [15:0]       limit,
	output logic              read_bit,
	output logic [15:0]       updates,
	output logic              overflow,
	output logic [9:0]        pending
);

	localparam int PA = lgep_pkg::PAD_AW;
	localparam int IW = lgep_pkg::ID_W;
	localparam int SW = lgep_pkg::SP_W;
	localparam int SA = lgep_pkg::STK_AW;

	logic [3:0] col_q, row_q;
	logic [1:0] side_q;
	logic level_q;
	logic [63:0] word_q;
	logic [PA-1:0] clr_q;
	logic [SW-1:0] sp_q;
	logic ovf_q;
	logic [15:0] cnt_q;
	logic [IW-1:0] id_q;
	logic [7:0] id_raw;
	logic [3:0] pat_q;
	logic [3:0] nv_q;
	logic [3:0] self_q;
	logic [63:0] tbl_rd;
	logic [1:0] kind_q;
	logic rb_q;
	logic pop_q;

	// state memory port signals
	logic s_we;
	logic [PA-1:0] s_wa, s_ra;
	logic [3:0] s_wd, s_rd;
	// stack port signals
	logic k_we;
	logic [SA-1:0] k_wa, k_ra;
	logic [7:0] k_wd;

	logic push_ok_raw;
	logic [3:0] pcol, prow;

	logic [8:0] c9, r9, pc, pr;
	logic [8:0] tc, tr;
	logic in_grid;
	logic t_we;

	assign in_grid = 1'b1;
	assign c9 = 9'(id_q[3:0]);
	assign r9 = 9'(id_q[IW-1:4]);
	assign pc = c9 + 9'd1;
	assign pr = r9 + 9'd1;

	// capture command fields
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			col_q <= col;
			row_q <= row;
			side_q <= side;
			level_q <= level;
			word_q <= table_word;
			kind_q <= kind;
		end
	end

	// stack pointer, overflow, update count, cleanup counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
			ovf_q <= 1'b0;
			clr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.clear_step) clr_q <= clr_q + PA'(1);
			if (cmd.capture) cnt_q <= '0;
			if (cmd.pop) sp_q <= sp_q - SW'(1);
			if (k_we) sp_q <= sp_q + SW'(1);
			if ((cmd.push_cmd || push_ok_raw) && sp_q == SW'(lgep_pkg::STACK_DEPTH))
				ovf_q <= 1'b1;
			if (cmd.eval_write) cnt_q <= cnt_q + 16'd1;
		end
	end

	// neighbor push selection
	always_comb begin
		pcol = id_q[3:0];
		prow = id_q[IW-1:4];
		push_ok_raw = 1'b0;
		if (cmd.push_nb) begin
			case (cmd.push_dir)
				2'd0: begin push_ok_raw = (prow != 4'd0); prow = prow - 4'd1; end
				2'd1: begin push_ok_raw = (pcol != 4'd15); pcol = pcol + 4'd1; end
				2'd2: begin push_ok_raw = (prow != 4'd15); prow = prow + 4'd1; end
				default: begin push_ok_raw = (pcol != 4'd0); pcol = pcol - 4'd1; end
			endcase
		end
	end

	always_comb begin
		k_we = (cmd.push_cmd || push_ok_raw) && (sp_q != SW'(lgep_pkg::STACK_DEPTH));
		k_wa = sp_q[SA-1:0];
		k_wd = cmd.push_cmd ? {row_q, col_q} : {prow, pcol};
		k_ra = SA'(sp_q - SW'(1));
	end

	lgep_ram #(.WIDTH(8), .DEPTH(lgep_pkg::STACK_DEPTH)) u_stack (
		.clk(clk), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(id_raw)
	);

	// popped cell id
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pop_q <= 1'b0;
		else pop_q <= cmd.pop;
	end
	always_ff @(posedge clk) begin
		if (pop_q) id_q <= id_raw[IW-1:0];
	end

	// state memory access
	always_comb begin
		tc = 9'(col_q) + 9'd1;
		tr = 9'(row_q) + 9'd1;
		case (side_q)
			2'd0: tr = tr - 9'd1;
			2'd1: tc = tc + 9'd1;
			2'd2: tr = tr + 9'd1;
			default: tc = tc - 9'd1;
		endcase
		s_we = 1'b0;
		s_wa = lgep_pkg::pad_idx(tc, tr);
		s_wd = level_q ? lgep_pkg::ALL_ONES : 4'd0;
		if (cmd.clear_step) begin
			s_we = 1'b1;
			s_wa = clr_q;
			s_wd = lgep_pkg::ALL_ONES;
		end else if (cmd.drive_set) begin
			s_we = 1'b1;
		end else if (cmd.eval_write) begin
			s_we = 1'b1;
			s_wa = lgep_pkg::pad_idx(pc, pr);
			s_wd = nv_q;
		end
		s_ra = lgep_pkg::pad_idx(pc, pr);
		if (cmd.read_rd) s_ra = lgep_pkg::pad_idx(9'(col_q) + 9'd1, 9'(row_q) + 9'd1);
		else if (!cmd.self_rd) begin
			case (cmd.nb_rd)
				2'd0: s_ra = lgep_pkg::pad_idx(pc, pr - 9'd1);
				2'd1: s_ra = lgep_pkg::pad_idx(pc + 9'd1, pr);
				2'd2: s_ra = lgep_pkg::pad_idx(pc, pr + 9'd1);
				default: s_ra = lgep_pkg::pad_idx(pc - 9'd1, pr);
			endcase
		end
	end

	lgep_ram #(.WIDTH(4), .DEPTH(lgep_pkg::NPAD)) u_state (
		.clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd)
	);

	// table memory: write on load, read at popped id
	assign t_we = cmd.capture && (lgep_pkg::kind_t'(kind) == lgep_pkg::KIND_LOAD);
	lgep_ram #(.WIDTH(64), .DEPTH(lgep_pkg::NCELLS)) u_table (
		.clk(clk), .we(t_we), .waddr({row, col}), .wdata(table_word),
		.raddr(id_q), .rdata(tbl_rd)
	);

	// collect incoming pattern, then look up new state
	always_ff @(posedge clk) begin
		if (cmd.nb_cap) begin
			case (cmd.nb_sel)
				3'd0: pat_q[0] <= s_rd[2];
				3'd1: pat_q[1] <= s_rd[3];
				3'd2: pat_q[2] <= s_rd[0];
				3'd3: begin
					pat_q[3] <= s_rd[1];
				end
				default: begin
					self_q <= s_rd;
					nv_q <= tbl_rd[{pat_q, 2'b00} +: 4];
				end
			endcase
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			rb_q <= (lgep_pkg::kind_t'(kind_q) == lgep_pkg::KIND_READ) ? s_rd[side_q] : 1'b0;
			updates <= cmd.is_prop ? cnt_q : 16'd0;
			overflow <= ovf_q;
			pending <= 10'(sp_q);
		end
	end
	assign read_bit = rb_q;

	assign st.clear_done = (clr_q == PA'(lgep_pkg::NPAD - 1));
	assign st.in_grid = in_grid;
	assign st.stack_empty = (sp_q == '0);
	assign st.at_limit = (cnt_q >= limit);
	assign st.id_valid = 1'b1;
	assign st.changed = (self_q != nv_q);

endmodule

### hdl/lut_grid_event_propagator.sv
// Grid event propagator: 16x16 cells with 4-bit states and 64-bit lookup tables.
// Input channel (in_valid/in_stall) takes one command: kind 0 loads a table,
// kind 1 drives a neighbor cell and queues the cell, kind 2 propagates queued
// work, kind 3 reads one output bit. Output channel (out_valid/out_stall)
// returns one result per command: read_bit, updates, overflow, pending.
// Propagate time is set by the single read port of the state memory (four
// neighbor reads plus self per popped cell) and by four serial stack pushes
// when the cell changes.
// After reset a clearing pass writes all ones to the 324 state entries while
// in_stall stays high; configuration writes work.
// One command is in flight at a time; a held result keeps in_stall high
// until the receiver takes it. iteration_limit sits at APB address 0.
module lut_grid_event_propagator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [3:0]  col,
	input  logic [3:0]  row,
	input  logic [1:0]  side,
	input  logic [63:0] table_word,
	input  logic        level,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        read_bit,
	output logic [15:0] updates,
	output logic        overflow,
	output logic [9:0]  pending
);

	logic [15:0] limit_q;
	lgep_pkg::cmd_t cmd;
	lgep_pkg::stat_t st;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {16'd0, limit_q} : 32'd0;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) limit_q <= 16'hFFFF;
		else if (psel && penable && pwrite && paddr == 2'd0) limit_q <= pwdata[15:0];
	end

	lgep_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .out_valid(out_valid), .out_stall(out_stall), .st(st), .cmd(cmd)
	);

	lgep_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st), .kind(kind), .col(col),
		.row(row), .side(side), .table_word(table_word), .level(level),
		.limit(limit_q), .read_bit(read_bit), .updates(updates),
		.overflow(overflow), .pending(pending)
	);

endmodule

### tb/lgep_checker.sv
module lgep_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [3:0]  col,
	input  logic [3:0]  row,
	input  logic [1:0]  side,
	input  logic [63:0] table_word,
	input  logic        level,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        read_bit,
	input  logic [15:0] updates,
	input  logic        overflow,
	input  logic [9:0]  pending,
	output int          mismatches,
	output int          awaiting
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REG_ITER_LIMIT = 2'd0;

	typedef struct packed {
		logic        rd_bit;
		logic [15:0] upd_cnt;
		logic        ovf;
		logic [9:0]  depth;
	} grid_result_t;

	// shadow copy of the grid
	logic [3:0]  cell_st [lgep_pkg::NPAD];
	logic [63:0] cell_tbl [lgep_pkg::NCELLS];
	logic [7:0]  work_q [lgep_pkg::STACK_DEPTH];
	int          work_sp;
	logic        ovf_sticky;
	logic [15:0] iter_limit;
	grid_result_t expected_results[$];

	function automatic int pad_at(int c, int r);
		return r * lgep_pkg::PAD_W + c;
	endfunction

	function automatic void queue_cell(int c, int r);
		if (work_sp >= lgep_pkg::STACK_DEPTH) begin
			ovf_sticky = 1'b1;
		end else begin
			work_q[work_sp] = 8'(r * lgep_pkg::GRID_W + c);
			work_sp++;
		end
	endfunction

	// pop work until empty or the limit is hit; return change count
	function automatic logic [15:0] settle_grid();
		int changes;
		int id, c, r;
		logic [3:0] pat, nv;
		changes = 0;
		while (work_sp > 0 && changes < iter_limit) begin
			work_sp--;
			id = work_q[work_sp];
			c = id % lgep_pkg::GRID_W;
			r = id / lgep_pkg::GRID_W;
			pat[0] = cell_st[pad_at(c + 1, r)][2];
			pat[1] = cell_st[pad_at(c + 2, r + 1)][3];
			pat[2] = cell_st[pad_at(c + 1, r + 2)][0];
			pat[3] = cell_st[pad_at(c, r + 1)][1];
			nv = cell_tbl[id][pat*4 +: 4];
			if (cell_st[pad_at(c + 1, r + 1)] != nv) begin
				cell_st[pad_at(c + 1, r + 1)] = nv;
				changes++;
				if (r > 0) queue_cell(c, r - 1);
				if (c + 1 < lgep_pkg::GRID_W) queue_cell(c + 1, r);
				if (r + 1 < lgep_pkg::GRID_H) queue_cell(c, r + 1);
				if (c > 0) queue_cell(c - 1, r);
			end
		end
		return 16'(changes);
	endfunction

	function automatic grid_result_t apply_command(lgep_pkg::kind_t k, int c, int r, int s,
			logic [63:0] w, logic l);
		grid_result_t res;
		int tc, tr;
		res = '0;
		case (k)
			lgep_pkg::KIND_LOAD: begin
				cell_tbl[r * lgep_pkg::GRID_W + c] = w;
			end
			lgep_pkg::KIND_DRIVE: begin
				tc = c + 1;
				tr = r + 1;
				case (s)
					0: tr--;
					1: tc++;
					2: tr++;
					default: tc--;
				endcase
				queue_cell(c, r);
				cell_st[pad_at(tc, tr)] = l ? lgep_pkg::ALL_ONES : 4'b0000;
			end
			lgep_pkg::KIND_PROP: begin
				res.upd_cnt = settle_grid();
			end
			default: begin
				res.rd_bit = cell_st[pad_at(c + 1, r + 1)][s];
			end
		endcase
		res.ovf = ovf_sticky;
		res.depth = 10'(work_sp);
		return res;
	endfunction

	initial begin
		foreach (cell_st[i]) cell_st[i] = lgep_pkg::ALL_ONES;
		foreach (cell_tbl[i]) cell_tbl[i] = '0;
		work_sp = 0;
		ovf_sticky = 1'b0;
		iter_limit = 16'hFFFF;
		mismatches = 0;
	end

	assign awaiting = expected_results.size();

	// track register writes, predict on input transfers, compare on output transfers
	always @(posedge clk) begin
		grid_result_t want, got;
		if (arst_n) begin
			if (psel && penable && pwrite && pready && paddr == REG_ITER_LIMIT)
				iter_limit <= pwdata[15:0];
			if (in_valid && !in_stall)
				expected_results.push_back(apply_command(lgep_pkg::kind_t'(kind), col, row,
					side, table_word, level));
			if (out_valid && !out_stall) begin
				got = '{read_bit, updates, overflow, pending};
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transfer: %p", got);
				end else begin
					want = expected_results.pop_front();
					if (got != want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p got %p", want, got);
					end
				end
			end
		end
	end

endmodule

### tb/tb_lut_grid_event_propagator.sv
module tb_lut_grid_event_propagator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REG_ITER_LIMIT = 2'd0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  kind = '0;
	logic [3:0]  col = '0, row = '0;
	logic [1:0]  side = '0;
	logic [63:0] table_word = '0;
	logic        level = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        read_bit, overflow;
	logic [15:0] updates;
	logic [9:0]  pending;
	int          mismatches, awaiting;
	logic        calm = 1'b0;

	lut_grid_event_propagator uut (.*);

	lgep_checker chk (.*);

	always #5 clk = ~clk;

	// give up long after the slowest legal run
	initial begin
		#80ms;
		$display("TB_ERROR");
		$finish;
	end

	// alternate calm stretches with random stalls on the result side
	always @(negedge clk) begin
		if ($urandom_range(0, 299) == 0) calm <= ~calm;
		if (calm) out_stall <= 1'b0;
		else if (out_stall) out_stall <= ($urandom_range(0, 9) < 7);
		else out_stall <= ($urandom_range(0, 9) < 3);
	end

	task automatic write_limit(logic [15:0] v);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= REG_ITER_LIMIT;
		pwdata <= {16'h0, v};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// drop valid and wait for every outstanding result
	task automatic drain();
		in_valid <= 1'b0;
		while (awaiting != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	// one command transfer with a random gap ahead of it; returns at the next
	// falling edge with valid still high
	task automatic send_cmd(lgep_pkg::kind_t k, logic [3:0] c, logic [3:0] r,
			logic [1:0] s, logic [63:0] w, logic l);
		int gap;
		gap = calm ? 0 : ($urandom_range(0, 19) == 0 ? $urandom_range(5, 40)
			: $urandom_range(0, 2));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		col <= c;
		row <= r;
		side <= s;
		table_word <= w;
		level <= l;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	function automatic logic [63:0] flat_table(logic [3:0] nib);
		return {16{nib}};
	endfunction

	initial begin
		logic [15:0] limits[6];
		int pick;
		limits = '{16'd1, 16'd7, 16'd40, 16'd200, 16'd3, 16'd1};
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		write_limit(16'hFFFF);

		// flat tables everywhere so every cell settles after one change
		for (int i = 0; i < lgep_pkg::NCELLS; i++)
			send_cmd(lgep_pkg::KIND_LOAD, 4'(i % lgep_pkg::GRID_W),
				4'(i / lgep_pkg::GRID_W), 2'd0,
				flat_table(4'($urandom_range(0, 15))), 1'b0);

		// directed: corners, every side, both levels, empty and full tables
		send_cmd(lgep_pkg::KIND_READ, 4'd0, 4'd0, 2'd0, '0, 1'b0);
		send_cmd(lgep_pkg::KIND_PROP, 4'd0, 4'd0, 2'd0, '0, 1'b0);
		send_cmd(lgep_pkg::KIND_LOAD, 4'd0, 4'd0, 2'd0, 64'h0, 1'b0);
		send_cmd(lgep_pkg::KIND_LOAD, 4'd15, 4'd15, 2'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
		for (int s = 0; s < 4; s++) begin
			send_cmd(lgep_pkg::KIND_DRIVE, 4'd0, 4'd0, 2'(s), '0, 1'b0);
			send_cmd(lgep_pkg::KIND_DRIVE, 4'd15, 4'd15, 2'(s), '0, 1'b1);
		end
		send_cmd(lgep_pkg::KIND_PROP, 4'd0, 4'd0, 2'd0, '0, 1'b0);
		for (int s = 0; s < 4; s++) begin
			send_cmd(lgep_pkg::KIND_READ, 4'd0, 4'd0, 2'(s), '0, 1'b0);
			send_cmd(lgep_pkg::KIND_READ, 4'd15, 4'd15, 2'(s), '0, 1'b0);
		end
		send_cmd(lgep_pkg::KIND_DRIVE, 4'd7, 4'd8, 2'd1, '0, 1'b0);
		send_cmd(lgep_pkg::KIND_PROP, 4'd0, 4'd0, 2'd0, '0, 1'b0);

		// random phases under small limits keep busy grids bounded
		foreach (limits[p]) begin
			drain();
			write_limit(limits[p]);
			for (int n = 0; n < 100; n++) begin
				pick = $urandom_range(0, 99);
				send_cmd(pick < 15 ? lgep_pkg::KIND_LOAD : pick < 50 ? lgep_pkg::KIND_DRIVE
					: pick < 75 ? lgep_pkg::KIND_PROP : lgep_pkg::KIND_READ,
					4'($urandom), 4'($urandom), 2'($urandom),
					{$urandom, $urandom}, 1'($urandom));
			end
		end

		drain();
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
